// ----- design/tdpt_pkg.sv -----
// ----------------------------------------------------------------------------
// Trial division prime test package
// Shared constants and the sequencer state type of the prime tester.
// ----------------------------------------------------------------------------
package tdpt_pkg;

   // Width of the candidate and echo fields on the ports.
   localparam int CANDIDATE_WIDTH = 32;

   // Default number of candidate bits that take part in the test.
   localparam int NUMBER_WIDTH_DEFAULT = 32;

   // Sequencer states, one-hot.
   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_CHECK  = 4'b0010,
      ST_DIVIDE = 4'b0100,
      ST_DONE   = 4'b1000
   } seq_state_type;

endpackage

// ----- design/trial_division_prime_test.sv -----
// ----------------------------------------------------------------------------
// Trial division prime test
// Tests one unsigned candidate word for primality by trial division.
// ----------------------------------------------------------------------------
// Usage:
// A candidate word enters on the req_ channel (req_valid, req_stall,
// req_candidate); only its low NUMBER_WIDTH bits are tested. One result
// word leaves on the rsp_ channel: the masked candidate and a prime flag.
// Zero and one are reported as not prime.
// The candidate is divided by 2 and then by 3, 5, 7, ... while the divisor
// squared does not exceed it. Each remainder comes from one shared
// restoring remainder unit that retires one dividend bit per cycle, so each
// divisor takes a bound check followed by a serial divide over all
// NUMBER_WIDTH candidate bits. The search stops at the first exact divisor.
// One candidate is in work at a time; req_stall is high while it runs. The
// result sits in an output register, so a new word is taken while the
// previous result still waits on a stalled receiver; a finished search
// waits for that register to free. Synchronous reset returns the sequencer
// to idle and drops rsp_valid.
// ----------------------------------------------------------------------------
module trial_division_prime_test #(
   parameter int NUMBER_WIDTH = tdpt_pkg::NUMBER_WIDTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [tdpt_pkg::CANDIDATE_WIDTH-1:0] req_candidate,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [tdpt_pkg::CANDIDATE_WIDTH-1:0] rsp_number_tested,
   output logic                                 rsp_is_prime
);
   import tdpt_pkg::*;

   // Divisor, square and bit counter widths follow the candidate width.
   localparam int DW = NUMBER_WIDTH / 2 + 1;
   localparam int SW = NUMBER_WIDTH + 2;
   localparam int CW = $clog2(NUMBER_WIDTH);

   seq_state_type           state_ff, state_in;
   logic [NUMBER_WIDTH-1:0] cand_ff, cand_in;
   logic [NUMBER_WIDTH-1:0] shift_ff, shift_in;
   logic [DW-1:0]           divisor_ff, divisor_in;
   logic [SW-1:0]           square_ff, square_in;
   logic [DW-1:0]           rem_ff, rem_in;
   logic [CW-1:0]           count_ff, count_in;
   logic                    prime_ff, prime_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [CANDIDATE_WIDTH-1:0] rsp_number_ff, rsp_number_in;
   logic                    rsp_prime_ff, rsp_prime_in;

   logic [NUMBER_WIDTH-1:0] req_masked;
   logic [DW:0]             trial;
   logic [DW:0]             trial_diff;
   logic [DW-1:0]           rem_next;
   logic                    rsp_free;

   assign req_masked = req_candidate[NUMBER_WIDTH-1:0];
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;

   // Shared remainder step: bring down the next dividend bit and subtract.
   assign trial      = {rem_ff, shift_ff[NUMBER_WIDTH-1]};
   assign trial_diff = trial - {1'b0, divisor_ff};
   assign rem_next   = (trial >= {1'b0, divisor_ff}) ? trial_diff[DW-1:0] : trial[DW-1:0];

   // Sequencer and datapath next-state logic.
   always_comb begin
      state_in      = state_ff;
      cand_in       = cand_ff;
      shift_in      = shift_ff;
      divisor_in    = divisor_ff;
      square_in     = square_ff;
      rem_in        = rem_ff;
      count_in      = count_ff;
      prime_in      = prime_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_number_in = rsp_number_ff;
      rsp_prime_in  = rsp_prime_ff;

      // The receiver takes the waiting result word.
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cand_in    = req_masked;
               divisor_in = DW'(2);
               square_in  = SW'(4);
               if (req_masked < NUMBER_WIDTH'(2)) begin
                  prime_in = 1'b0;
                  state_in = ST_DONE;
               end else begin
                  prime_in = 1'b1;
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            // Stop once the divisor squared passes the candidate.
            if (square_ff > SW'(cand_ff)) begin
               state_in = ST_DONE;
            end else begin
               shift_in = cand_ff;
               rem_in   = '0;
               count_in = CW'(NUMBER_WIDTH - 1);
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            rem_in   = rem_next;
            shift_in = {shift_ff[NUMBER_WIDTH-2:0], 1'b0};
            count_in = count_ff - CW'(1);
            if (count_ff == '0) begin
               if (rem_next == '0) begin
                  prime_in = 1'b0;
                  state_in = ST_DONE;
               end else begin
                  // Step to the next divisor: 2 goes to 3, odd ones go up by 2.
                  if (divisor_ff == DW'(2)) begin
                     divisor_in = DW'(3);
                     square_in  = SW'(9);
                  end else begin
                     divisor_in = divisor_ff + DW'(2);
                     square_in  = square_ff + SW'({divisor_ff + DW'(1), 2'b00});
                  end
                  state_in = ST_CHECK;
               end
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_number_in = CANDIDATE_WIDTH'(cand_ff);
               rsp_prime_in  = prime_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath and result registers.
   always_ff @(posedge clock) begin
      cand_ff       <= cand_in;
      shift_ff      <= shift_in;
      divisor_ff    <= divisor_in;
      square_ff     <= square_in;
      rem_ff        <= rem_in;
      count_ff      <= count_in;
      prime_ff      <= prime_in;
      rsp_number_ff <= rsp_number_in;
      rsp_prime_ff  <= rsp_prime_in;
   end

   assign req_stall         = (state_ff != ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_number_tested = rsp_number_ff;
   assign rsp_is_prime      = rsp_prime_ff;

   // The running square always matches the divisor at a bound check.
   a_square_tracks : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHECK) |-> (square_ff == SW'(SW'(divisor_ff) * SW'(divisor_ff))))
      else $error("divisor square out of step");

   // Only 2 and odd numbers are ever tried as divisors.
   a_divisor_odd : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHECK) |-> (divisor_ff[0] || divisor_ff == DW'(2)))
      else $error("even divisor other than two");

   // The partial remainder stays below the divisor during a divide.
   a_rem_bound : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE) |-> (rem_ff < divisor_ff))
      else $error("partial remainder not below divisor");

   // Zero, one and even numbers above two are never reported prime.
   a_prime_sane : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_is_prime) |->
         (rsp_number_tested > CANDIDATE_WIDTH'(1)) &&
         (rsp_number_tested[0] || rsp_number_tested == CANDIDATE_WIDTH'(2)))
      else $error("impossible prime reported");

   // A finished search only leaves when the result register can take it.
   a_done_wait : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && rsp_valid && rsp_stall) |=> (state_ff == ST_DONE))
      else $error("result overwritten while stalled");

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trial division prime test bench
// Feeds candidate words to the prime tester and checks each result word
// against a trial-division verdict computed here. Both channels idle and
// stall at random, the receiver once holds off long enough to fill the
// block, and the sender once drains the block before it goes on.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int CW           = tdpt_pkg::CANDIDATE_WIDTH;
   localparam int NUMBER_WIDTH = tdpt_pkg::NUMBER_WIDTH_DEFAULT;
   localparam int RANDOM_WORDS = 100;
   localparam int LONG_HOLD    = 40_000;
   localparam int DRAIN_CYCLES = 40;
   localparam longint TIMEOUT_NS = 200_000_000;

   // Scoreboard: keeps the verdicts still owed by the block, oldest first.
   class prime_scoreboard;
      typedef struct packed {
         logic [CW-1:0] number;
         logic          is_prime;
      } prime_verdict_type;

      prime_verdict_type awaited_verdicts[$];
      int                mismatch_count;

      function new();
         mismatch_count = 0;
      endfunction

      // Trial division by 2, then 3, 5, 7, ... while the divisor squared fits.
      function bit divisor_search_verdict(logic [CW-1:0] n);
         longint unsigned d;
         if (n < 2) return 1'b0;
         d = 2;
         while (d * d <= n) begin
            if (n % d == 0) return 1'b0;
            d = (d == 2) ? 3 : d + 2;
         end
         return 1'b1;
      endfunction

      // An accepted candidate word owes one verdict on its masked value.
      function void note_candidate(logic [CW-1:0] candidate);
         prime_verdict_type v;
         logic [CW-1:0]     mask;
         mask       = CW'((65'd1 << NUMBER_WIDTH) - 65'd1);
         v.number   = candidate & mask;
         v.is_prime = divisor_search_verdict(v.number);
         awaited_verdicts.push_back(v);
      endfunction

      // Compare one accepted result word with the oldest owed verdict.
      function void check_result(logic [CW-1:0] got_number, logic got_prime);
         prime_verdict_type want;
         if (awaited_verdicts.size() == 0) begin
            $display("%0t: unexpected result word: expected none, actual %0d / %0b",
                     $time, got_number, got_prime);
            mismatch_count++;
            return;
         end
         want = awaited_verdicts.pop_front();
         if (got_number !== want.number) begin
            $display("%0t: number_tested mismatch: expected %0d, actual %0d",
                     $time, want.number, got_number);
            mismatch_count++;
         end
         if (got_prime !== want.is_prime) begin
            $display("%0t: is_prime mismatch for %0d: expected %0b, actual %0b",
                     $time, want.number, want.is_prime, got_prime);
            mismatch_count++;
         end
      endfunction
   endclass

   logic          clock;
   logic          reset;
   logic          req_valid;
   logic          req_stall;
   logic [CW-1:0] req_candidate;
   logic          rsp_valid;
   logic          rsp_stall;
   logic [CW-1:0] rsp_number_tested;
   logic          rsp_is_prime;

   prime_scoreboard board;
   int              results_seen;

   trial_division_prime_test #(
      .NUMBER_WIDTH(NUMBER_WIDTH)
   ) DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_candidate    (req_candidate),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_number_tested(rsp_number_tested),
      .rsp_is_prime     (rsp_is_prime)
   );

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Offer one candidate word after an idle gap and hold it until taken.
   task automatic send_candidate(input logic [CW-1:0] n, input int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_candidate <= n;
      do @(posedge clock); while (req_stall !== 1'b0);
      board.note_candidate(n);
   endtask

   // Random candidates: mostly small, some medium, and wide composites that
   // carry a small factor so the search stays short.
   function automatic logic [CW-1:0] draw_candidate();
      int unsigned small_factors[6] = '{2, 3, 5, 7, 11, 13};
      int unsigned p;
      int unsigned k;
      int          pick;
      pick = $urandom_range(0, 99);
      if (pick < 15) return CW'($urandom_range(0, 255));
      if (pick < 65) return CW'($urandom_range(0, 65535));
      if (pick < 75) return CW'($urandom_range(0, 1 << 20));
      p = small_factors[$urandom_range(0, 5)];
      k = $urandom_range(0, 32'hFFFF_FFFF / p);
      return CW'(p * k);
   endfunction

   // Sender: reset, directed words, a full drain, then random words.
   initial begin
      logic [CW-1:0] directed_words[$];
      int            idx;
      int            gap;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_candidate = '0;
      board         = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Zero and one, two and three, squares on the bound, edge bit patterns.
      directed_words = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd9, 32'd25,
                         32'd49, 32'd97, 32'd65521, 32'd65536, 32'd65537,
                         32'd16777213, 32'd16752649, 32'hFFFF_FFFF, 32'h8000_0000,
                         32'hFFFF_FFFE, 32'hAAAA_AAAA, 32'h5555_5555,
                         32'd4294836225, 32'd7, 32'd8};
      foreach (directed_words[i])
         send_candidate(directed_words[i], $urandom_range(0, 5));

      // Let the block drain completely before the random part.
      req_valid <= 1'b0;
      while (board.awaited_verdicts.size() != 0) @(posedge clock);

      for (idx = 0; idx < RANDOM_WORDS; idx++) begin
         // Stretches of back-to-back words between idle gaps.
         gap = (idx % 30 < 8) ? 0 : $urandom_range(0, 5);
         send_candidate(draw_candidate(), gap);
      end
      req_valid <= 1'b0;

      // Wait for every owed verdict, then watch for strays.
      while (board.awaited_verdicts.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (board.mismatch_count == 0 && board.awaited_verdicts.size() == 0)
         $display("trial_division_prime_test test passed");
      else
         $display("trial_division_prime_test test failed");
      $finish;
   end

   // Receiver: random stall before each result word, one long hold-off.
   initial begin
      int  gap;
      bit  held_long;
      held_long    = 1'b0;
      rsp_stall    = 1'b0;
      results_seen = 0;
      wait (reset === 1'b0);
      forever begin
         if (!held_long && results_seen == 30) begin
            gap       = LONG_HOLD;
            held_long = 1'b1;
         end else if (results_seen % 25 < 6) begin
            gap = 0;
         end else begin
            gap = $urandom_range(0, 5);
         end
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         board.check_result(rsp_number_tested, rsp_is_prime);
         results_seen++;
      end
   end

   // Watchdog for a hung block.
   initial begin
      #(TIMEOUT_NS);
      $display("trial_division_prime_test test failed");
      $finish;
   end

endmodule
